// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, a) \
   label: assert property (@(posedge clk) disable iff (rst) !(a)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEVER(label, clk, rst, a)
`endif
`endif

// ===== src/tfn_pkg.sv =====
// ----------------------------------------------------------------------------
// tfn_pkg
// types and constants shared by the triangle face normal pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tfn_pkg;
   localparam int COORD_W   = 16;
   localparam int OUT_W     = 16;
   localparam int MAG_W     = 34;
   localparam int SUM_W     = 70;
   localparam int ROOT_W    = 36;
   localparam int NORMAL_FRAC_BITS_DEF = 14;

   typedef struct packed {
      logic signed [COORD_W-1:0] v0_x;
      logic signed [COORD_W-1:0] v0_y;
      logic signed [COORD_W-1:0] v0_z;
      logic signed [COORD_W-1:0] v1_x;
      logic signed [COORD_W-1:0] v1_y;
      logic signed [COORD_W-1:0] v1_z;
      logic signed [COORD_W-1:0] v2_x;
      logic signed [COORD_W-1:0] v2_y;
      logic signed [COORD_W-1:0] v2_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] normal_x;
      logic signed [OUT_W-1:0] normal_y;
      logic signed [OUT_W-1:0] normal_z;
      logic                    degenerate;
   } rsp_type;

   // cross product as sign and magnitude per component
   typedef struct packed {
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
   } vec_type;
endpackage

// ===== src/triangle_face_normal.sv =====
// throughput: one triangle per cycle, busy is always low
// the depth is set by the square root (one root bit per stage) and the divider
// (one quotient bit per stage)
// reset clears the valid bits of every stage; the receiver cannot stall
// ----------------------------------------------------------------------------
// triangle_face_normal
// unit face normal of a triangle in signed Q1.14, pipelined
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module triangle_face_normal #(
   parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tfn_pkg::req_type req_data,
   output logic             rsp_valid,
   output tfn_pkg::rsp_type rsp_data
);
   import tfn_pkg::*;

   localparam int QW  = NORMAL_FRAC_BITS + 1;
   localparam int LAT = 43 + NORMAL_FRAC_BITS;

   logic              cr_valid, sq_valid, rt_valid;
   vec_type           cr_vec, sq_vec, rt_vec;
   logic [SUM_W-1:0]  sq_sum;
   logic [ROOT_W-1:0] rt_root;
   logic              rt_zero;
   logic [2:0]        dv_valid;
   logic [QW-1:0]     dv_quot [3];
   logic [QW-1:0]     neg_ff [3];
   logic [QW-1:0]     degen_ff;
   logic              out_valid_ff;
   rsp_type           out_ff;
   logic [OUT_W-1:0]  comp_in [3];

   assign busy = 1'b0;

   tfn_cross u_cross (
      .clock, .reset,
      .in_valid (start),
      .in_data  (req_data),
      .out_valid(cr_valid),
      .out_data (cr_vec)
   );

   tfn_sumsq u_sumsq (
      .clock, .reset,
      .in_valid (cr_valid),
      .in_data  (cr_vec),
      .out_valid(sq_valid),
      .out_data (sq_vec),
      .out_sum  (sq_sum)
   );

   tfn_sqrt u_sqrt (
      .clock, .reset,
      .in_valid (sq_valid),
      .in_data  (sq_vec),
      .in_sum   (sq_sum),
      .out_valid(rt_valid),
      .out_data (rt_vec),
      .out_root (rt_root),
      .out_zero (rt_zero)
   );

   for (genvar k = 0; k < 3; k++) begin : g_div
      tfn_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
         .clock, .reset,
         .in_valid (rt_valid),
         .in_mag   (rt_vec.mag[k]),
         .in_len   (rt_root),
         .out_valid(dv_valid[k]),
         .out_quot (dv_quot[k])
      );

      // sign bits ride alongside the divider
      always_ff @(posedge clock) begin
         neg_ff[k] <= {neg_ff[k][QW-2:0], rt_vec.neg[k]};
      end
   end

   always_ff @(posedge clock) begin
      degen_ff <= {degen_ff[QW-2:0], rt_zero};
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         comp_in[i] = neg_ff[i][QW-1] ? OUT_W'(-OUT_W'(dv_quot[i]))
                                      : OUT_W'(dv_quot[i]);
         if (degen_ff[QW-1]) begin
            comp_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      out_ff.normal_x   <= comp_in[0];
      out_ff.normal_y   <= comp_in[1];
      out_ff.normal_z   <= comp_in[2];
      out_ff.degenerate <= degen_ff[QW-1];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `ASSERT_NEVER(a_never_busy, clock, reset, busy)
   `ASSERT_IMPLIES(a_degen_zero, clock, reset, rsp_valid && rsp_data.degenerate, rsp_data.normal_x == '0 && rsp_data.normal_y == '0 && rsp_data.normal_z == '0)
   `ASSERT_IMPLIES(a_lanes_aligned, clock, reset, dv_valid[0], dv_valid[1] && dv_valid[2])
   `ASSERT_IMPLIES(a_latency, clock, reset, rsp_valid, $past(start, LAT))
endmodule

// ===== src/tfn_cross.sv =====
// ----------------------------------------------------------------------------
// tfn_cross
// edge vectors and cross product, three register stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tfn_cross (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  tfn_pkg::req_type in_data,
   output logic             out_valid,
   output tfn_pkg::vec_type out_data
);
   import tfn_pkg::*;

   logic [2:0] valid_ff;
   logic signed [16:0] ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff;
   logic signed [33:0] p_ff [6];
   vec_type vec_ff;
   logic signed [34:0] c_in [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      ax_ff <= 17'(in_data.v0_x) - 17'(in_data.v1_x);
      ay_ff <= 17'(in_data.v0_y) - 17'(in_data.v1_y);
      az_ff <= 17'(in_data.v0_z) - 17'(in_data.v1_z);
      bx_ff <= 17'(in_data.v1_x) - 17'(in_data.v2_x);
      by_ff <= 17'(in_data.v1_y) - 17'(in_data.v2_y);
      bz_ff <= 17'(in_data.v1_z) - 17'(in_data.v2_z);
   end

   always_ff @(posedge clock) begin
      p_ff[0] <= 34'(ay_ff * bz_ff);
      p_ff[1] <= 34'(az_ff * by_ff);
      p_ff[2] <= 34'(az_ff * bx_ff);
      p_ff[3] <= 34'(ax_ff * bz_ff);
      p_ff[4] <= 34'(ax_ff * by_ff);
      p_ff[5] <= 34'(ay_ff * bx_ff);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_in[i] = 35'(p_ff[2*i]) - 35'(p_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         vec_ff.neg[i] <= c_in[i][34];
         vec_ff.mag[i] <= c_in[i][34] ? MAG_W'(-c_in[i]) : MAG_W'(c_in[i]);
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = vec_ff;
endmodule

// ===== src/tfn_sumsq.sv =====
// ----------------------------------------------------------------------------
// tfn_sumsq
// squared length of the cross product, two register stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tfn_sumsq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  tfn_pkg::vec_type           in_data,
   output logic                       out_valid,
   output tfn_pkg::vec_type           out_data,
   output logic [tfn_pkg::SUM_W-1:0]  out_sum
);
   import tfn_pkg::*;

   logic [1:0] valid_ff;
   logic [2*MAG_W-1:0] sq_ff [3];
   vec_type vec1_ff, vec2_ff;
   logic [SUM_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= in_data.mag[i] * in_data.mag[i];
      end
      vec1_ff <= in_data;
      sum_ff  <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      vec2_ff <= vec1_ff;
   end

   assign out_valid = valid_ff[1];
   assign out_data  = vec2_ff;
   assign out_sum   = sum_ff;
endmodule

// ===== src/tfn_sqrt.sv =====
// ----------------------------------------------------------------------------
// tfn_sqrt
// floor square root, one root bit per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tfn_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  tfn_pkg::vec_type           in_data,
   input  logic [tfn_pkg::SUM_W-1:0]  in_sum,
   output logic                       out_valid,
   output tfn_pkg::vec_type           out_data,
   output logic [tfn_pkg::ROOT_W-1:0] out_root,
   output logic                       out_zero
);
   import tfn_pkg::*;

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   logic [ROOT_W-1:0] valid_ff;
   vec_type           vec_ff  [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] zero_ff;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic              src_valid, src_zero;
      vec_type           src_vec;
      logic [RAD_W-1:0]  src_rad;
      logic [REM_W-1:0]  src_rem, rem2, trial;
      logic [ROOT_W-1:0] src_root;

      if (i == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_vec   = in_data;
         assign src_rad   = RAD_W'(in_sum);
         assign src_rem   = '0;
         assign src_root  = '0;
         assign src_zero  = (in_sum == '0);
      end else begin : g_body
         assign src_valid = valid_ff[i-1];
         assign src_vec   = vec_ff[i-1];
         assign src_rad   = rad_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_root  = root_ff[i-1];
         assign src_zero  = zero_ff[i-1];
      end

      assign rem2  = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
      assign trial = REM_W'({src_root, 2'b01});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         vec_ff[i]  <= src_vec;
         zero_ff[i] <= src_zero;
         rad_ff[i]  <= {src_rad[RAD_W-3:0], 2'b00};
         if (rem2 >= trial) begin
            rem_ff[i]  <= rem2 - trial;
            root_ff[i] <= {src_root[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff[i]  <= rem2;
            root_ff[i] <= {src_root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_data  = vec_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_zero  = zero_ff[ROOT_W-1];
endmodule

// ===== src/tfn_div.sv =====
// ----------------------------------------------------------------------------
// tfn_div
// restoring divider, magnitude scaled by the fraction width over the length
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tfn_div #(
   parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [tfn_pkg::MAG_W-1:0]  in_mag,
   input  logic [tfn_pkg::ROOT_W-1:0] in_len,
   output logic                       out_valid,
   output logic [NORMAL_FRAC_BITS:0]  out_quot
);
   import tfn_pkg::*;

   localparam int QW  = NORMAL_FRAC_BITS + 1;
   localparam int DRW = ROOT_W + 1;

   logic [QW-1:0]     valid_ff;
   logic [DRW-1:0]    rem_ff  [QW];
   logic [QW-1:0]     low_ff  [QW];
   logic [QW-1:0]     quot_ff [QW];
   logic [ROOT_W-1:0] len_ff  [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic              src_valid;
      logic [DRW-1:0]    src_rem, rem2;
      logic [QW-1:0]     src_low, src_quot;
      logic [ROOT_W-1:0] src_len;

      if (i == 0) begin : g_head
         // the quotient fits in QW bits, so the top of the dividend starts as remainder
         assign src_valid = in_valid;
         assign src_rem   = DRW'(in_mag >> 1);
         assign src_low   = {in_mag[0], {NORMAL_FRAC_BITS{1'b0}}};
         assign src_quot  = '0;
         assign src_len   = in_len;
      end else begin : g_body
         assign src_valid = valid_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_low   = low_ff[i-1];
         assign src_quot  = quot_ff[i-1];
         assign src_len   = len_ff[i-1];
      end

      assign rem2 = {src_rem[DRW-2:0], src_low[QW-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         len_ff[i] <= src_len;
         low_ff[i] <= src_low << 1;
         if (rem2 >= DRW'(src_len)) begin
            rem_ff[i]  <= rem2 - DRW'(src_len);
            quot_ff[i] <= {src_quot[QW-2:0], 1'b1};
         end else begin
            rem_ff[i]  <= rem2;
            quot_ff[i] <= {src_quot[QW-2:0], 1'b0};
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
endmodule

// ===== sim/triangle_face_normal_tb.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal_tb
// drives triangles into the face normal pipeline in random bursts and checks
// every normal and degenerate flag against a behavioural cross product,
// square root and divide worked out in wide integers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module triangle_face_normal_tb;
   import tfn_pkg::*;

   localparam int LATENCY = 43 + NORMAL_FRAC_BITS_DEF;
   localparam int REQ_W   = $bits(req_type);

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type normal_queue[$];
   int      fail_count;

   triangle_face_normal i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #50_000_000;
      $display("** triangle_face_normal: FAILED **");
      $finish;
   end

   // floor square root, one root bit at a time
   function automatic logic [ROOT_W-1:0] floor_root(input logic [SUM_W-1:0] s);
      logic [ROOT_W-1:0] r;
      logic [ROOT_W-1:0] t;
      logic [2*ROOT_W-1:0] sq;
      r = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         t = r | (ROOT_W'(1) << b);
         sq = t * t;
         if (sq <= s) r = t;
      end
      return r;
   endfunction

   function automatic rsp_type face_normal(input req_type t);
      longint ax, ay, az, bx, by, bz;
      longint c[3];
      logic [SUM_W-1:0] len2;
      logic [ROOT_W-1:0] len;
      logic [63:0] m;
      logic [127:0] q;
      logic [OUT_W-1:0] n[3];
      rsp_type r;
      ax = longint'(t.v0_x) - longint'(t.v1_x);
      ay = longint'(t.v0_y) - longint'(t.v1_y);
      az = longint'(t.v0_z) - longint'(t.v1_z);
      bx = longint'(t.v1_x) - longint'(t.v2_x);
      by = longint'(t.v1_y) - longint'(t.v2_y);
      bz = longint'(t.v1_z) - longint'(t.v2_z);
      c[0] = ay * bz - az * by;
      c[1] = az * bx - ax * bz;
      c[2] = ax * by - ay * bx;
      len2 = '0;
      for (int i = 0; i < 3; i++) begin
         m = (c[i] < 0) ? 64'(-c[i]) : 64'(c[i]);
         len2 = len2 + SUM_W'(m) * SUM_W'(m);
      end
      r = '0;
      if (len2 == '0) begin
         r.degenerate = 1'b1;
         return r;
      end
      len = floor_root(len2);
      for (int i = 0; i < 3; i++) begin
         m = (c[i] < 0) ? 64'(-c[i]) : 64'(c[i]);
         q = (128'(m) << NORMAL_FRAC_BITS_DEF) / 128'(len);
         if (c[i] < 0) q = -q;
         n[i] = q[OUT_W-1:0];
      end
      r.normal_x = n[0];
      r.normal_y = n[1];
      r.normal_z = n[2];
      return r;
   endfunction

   // queue the expected normal at the tail
   function automatic void queue_normal(input req_type t);
      normal_queue.insert(normal_queue.size(), face_normal(t));
   endfunction

   // results cannot be held off, so every strobe is one beat
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (normal_queue.size() == 0) begin
            $error("unexpected result beat");
            fail_count++;
         end else begin
            want = normal_queue.pop_front();
            if (rsp_data.normal_x !== want.normal_x) begin
               $error("normal_x expected %0d got %0d", want.normal_x,
                      rsp_data.normal_x);
               fail_count++;
            end
            if (rsp_data.normal_y !== want.normal_y) begin
               $error("normal_y expected %0d got %0d", want.normal_y,
                      rsp_data.normal_y);
               fail_count++;
            end
            if (rsp_data.normal_z !== want.normal_z) begin
               $error("normal_z expected %0d got %0d", want.normal_z,
                      rsp_data.normal_z);
               fail_count++;
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               $error("degenerate expected %0b got %0b", want.degenerate,
                      rsp_data.degenerate);
               fail_count++;
            end
         end
      end
   end

   int burst_left;

   // one beat; start stays high across back to back beats
   task automatic send_triangle(input req_type t);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      queue_normal(t);
   endtask

   task automatic send_burst(input req_type t);
      start    <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      queue_normal(t);
   endtask

   function automatic logic [COORD_W-1:0] rand_coord(input int mode);
      case (mode)
         0: return COORD_W'($urandom_range(0, 15) - 8);
         1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   task automatic drain;
      int guard;
      guard = 0;
      start <= 1'b0;
      while (normal_queue.size() != 0 && guard < 10 * LATENCY) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic test_directed;
      req_type t;
      // extremes along each axis
      t = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
            16'h7fff, 16'h7fff, 16'h8000};
      send_triangle(t);
      t = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
            16'h8000, 16'h8000, 16'h7fff};
      send_triangle(t);
      t = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
            16'h8000, 16'h8000, 16'h7fff};
      send_triangle(t);
      // zero cross product: all equal, collinear, and all zero
      t = '0;
      send_triangle(t);
      t = '{16'h1234, 16'h8000, 16'h7fff, 16'h1234, 16'h8000, 16'h7fff,
            16'h1234, 16'h8000, 16'h7fff};
      send_triangle(t);
      t = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0200, 16'h0300,
            16'h0200, 16'h0400, 16'h0600};
      send_triangle(t);
      // axis normals: z in both windings, then +x and -y, then one small mixed-sign triangle
      t = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
            16'h0100, 16'h0100, 16'h0000};
      send_triangle(t);
      t = '{16'h0100, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
            16'h0000, 16'h0000, 16'h0000};
      send_triangle(t);
      t = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000,
            16'h0000, 16'h0000, 16'h0001};
      send_triangle(t);
      t = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
            16'h0000, 16'h0000, 16'h0001};
      send_triangle(t);
      t = '{16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0001,
            16'h0002, 16'h0003, 16'hfffe};
      send_triangle(t);
      drain();
   endtask

   task automatic test_random;
      req_type t;
      int mode;
      for (int n = 0; n < 900; n++) begin
         mode = $urandom_range(0, 9);
         t.v0_x = rand_coord(mode % 3);
         t.v0_y = rand_coord(mode % 3);
         t.v0_z = rand_coord(mode % 3);
         t.v1_x = rand_coord(mode % 3);
         t.v1_y = rand_coord(mode % 3);
         t.v1_z = rand_coord(mode % 3);
         t.v2_x = rand_coord(mode % 3);
         t.v2_y = rand_coord(mode % 3);
         t.v2_z = rand_coord(mode % 3);
         // occasional repeated vertex gives a degenerate triangle
         if (mode == 9) t.v2_x = t.v1_x;
         if (mode == 9) t.v2_y = t.v1_y;
         if (mode == 9) t.v2_z = t.v1_z;
         send_triangle(t);
         if (n == 450) drain();
      end
      drain();
   endtask

   task automatic test_back_to_back;
      req_type t;
      for (int n = 0; n < 40; n++) begin
         t = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
         send_burst(t);
      end
      drain();
   endtask

   initial begin
      fail_count = 0;
      burst_left = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_back_to_back();
      repeat (LATENCY + 10) @(posedge clock);
      if (normal_queue.size() != 0) begin
         $error("%0d results never arrived", normal_queue.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("** triangle_face_normal: PASSED **");
      end else begin
         $display("** triangle_face_normal: FAILED **");
      end
      $finish;
   end
endmodule
